// ----- hdl/masked_pattern_instruction_decoder_macros.svh -----
// assertion macros shared by the decoder rtl
`ifndef MASKED_PATTERN_INSTRUCTION_DECODER_MACROS_SVH
`define MASKED_PATTERN_INSTRUCTION_DECODER_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define MPID_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPID_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPID_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/mpid_pkg.sv -----
package mpid_pkg;

    localparam int SLOT_W = 6;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 10;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // token moving down the chain
    // load:   a = mask, b = value, c = index
    // decode: a = word, b = best mask so far, c = best index so far
    typedef struct packed {
        logic              vld;
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              ev;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [IDX_W-1:0]  c;
        logic              found;
    } tok_t;

endpackage

// ----- hdl/mpid_req_if.sv -----
interface mpid_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [mpid_pkg::SLOT_W-1:0]      slot;
    logic                             entry_valid;
    logic [mpid_pkg::WORD_W-1:0]      entry_mask;
    logic [mpid_pkg::WORD_W-1:0]      entry_value;
    logic [mpid_pkg::IDX_W-1:0]       entry_index;
    logic [mpid_pkg::WORD_W-1:0]      instr_word;

    modport source (
        output valid, req_type, slot, entry_valid, entry_mask, entry_value,
               entry_index, instr_word,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot, entry_valid, entry_mask, entry_value,
               entry_index, instr_word,
        output ready
    );
endinterface

// ----- hdl/mpid_rsp_if.sv -----
interface mpid_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [mpid_pkg::IDX_W-1:0]  instr_index;

    modport source (
        output valid, hit, instr_index,
        input  ready
    );

    modport sink (
        input  valid, hit, instr_index,
        output ready
    );
endinterface

// ----- hdl/mpid_cell.sv -----
module mpid_cell #(
    parameter int POS = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  mpid_pkg::tok_t  tok_in,
    output mpid_pkg::tok_t  tok_out
);

    logic                          pat_vld_reg;
    logic                          pat_vld_next;
    logic [mpid_pkg::WORD_W-1:0]   pat_mask_reg;
    logic [mpid_pkg::WORD_W-1:0]   pat_mask_next;
    logic [mpid_pkg::WORD_W-1:0]   pat_value_reg;
    logic [mpid_pkg::WORD_W-1:0]   pat_value_next;
    logic [mpid_pkg::IDX_W-1:0]    pat_index_reg;
    logic [mpid_pkg::IDX_W-1:0]    pat_index_next;

    logic                          tok_vld_reg;
    logic                          tok_vld_next;
    mpid_pkg::tok_t                tok_reg;
    mpid_pkg::tok_t                tok_next;

    logic                          slot_hit;
    logic                          match;

    assign slot_hit = (32'(tok_in.slot) == 32'(POS));
    assign match    = pat_vld_reg
                    && ((tok_in.a & pat_mask_reg) == pat_value_reg)
                    && (!tok_in.found || (pat_mask_reg > tok_in.b));

    always_comb
    begin
        pat_vld_next   = pat_vld_reg;
        pat_mask_next  = pat_mask_reg;
        pat_value_next = pat_value_reg;
        pat_index_next = pat_index_reg;
        tok_next       = tok_in;
        tok_vld_next   = tok_in.vld;
        if (tok_in.vld)
        begin
            unique case (tok_in.op)
                mpid_pkg::OP_LOAD:
                begin
                    if (slot_hit)
                    begin
                        pat_vld_next = tok_in.ev;
                        if (tok_in.ev)
                        begin
                            pat_mask_next  = tok_in.a;
                            pat_value_next = tok_in.b;
                            pat_index_next = tok_in.c;
                        end
                    end
                end
                mpid_pkg::OP_DECODE:
                begin
                    if (match)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.b     = pat_mask_reg;
                        tok_next.c     = pat_index_reg;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_vld_reg <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pat_vld_reg <= pat_vld_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pat_mask_reg  <= pat_mask_next;
            pat_value_reg <= pat_value_next;
            pat_index_reg <= pat_index_next;
            tok_reg       <= tok_next;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = tok_vld_reg;
    end

endmodule

// ----- hdl/masked_pattern_instruction_decoder.sv -----
// channel | dir | fields                                               | handshake
// req     | in  | req_type slot entry_valid entry_mask entry_value     | valid/ready
//         |     | entry_index instr_word                               |
// rsp     | out | hit instr_index                                      | valid/ready
//
// one request transaction is taken per cycle while the chain moves
// a transaction passes one cell per cycle while the chain moves: cell 0 loads at
// the accepting edge, each further cell registers it in turn, and the output
// register follows the last cell
// reset clears all pattern valid bits and empties the chain at once
// a held result on rsp freezes the whole chain, so req.ready drops with it
`include "masked_pattern_instruction_decoder_macros.svh"

module masked_pattern_instruction_decoder #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    mpid_req_if.sink    req,
    mpid_rsp_if.source  rsp
);

    // tok[k] feeds cell k, tok[ENTRIES] leaves the last cell
    mpid_pkg::tok_t              tok [ENTRIES+1];
    logic [ENTRIES-1:0]          chain_vld;
    logic                        adv;

    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic                        out_hit_reg;
    logic                        out_hit_next;
    logic [mpid_pkg::IDX_W-1:0]  out_idx_reg;
    logic [mpid_pkg::IDX_W-1:0]  out_idx_next;

    // the chain moves unless a result sits unclaimed at the output
    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // new transaction enters cell 0; decode starts with no best match
    always_comb
    begin
        tok[0].vld  = req.valid;
        tok[0].op   = mpid_pkg::op_t'(req.req_type);
        tok[0].slot = req.slot;
        tok[0].ev   = req.entry_valid;
        if (req.req_type == mpid_pkg::OP_DECODE)
        begin
            tok[0].a = req.instr_word;
            tok[0].b = '0;
            tok[0].c = '0;
        end
        else
        begin
            tok[0].a = req.entry_mask;
            tok[0].b = req.entry_value;
            tok[0].c = req.entry_index;
        end
        tok[0].found = 1'b0;
    end

    // one cell per pattern slot; lower slots are visited first so a
    // strictly greater mask is needed to replace an earlier match
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        mpid_cell #(
            .POS (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
        assign chain_vld[k] = tok[k+1].vld;
    end

    // only decode transactions produce a result; loads drop off the end
    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_hit_next = out_hit_reg;
        out_idx_next = out_idx_reg;
        if (adv)
        begin
            out_vld_next = tok[ENTRIES].vld && (tok[ENTRIES].op == mpid_pkg::OP_DECODE);
            out_hit_next = tok[ENTRIES].found;
            out_idx_next = tok[ENTRIES].found ? tok[ENTRIES].c : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
        out_idx_reg <= out_idx_next;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.instr_index = out_idx_reg;

    `MPID_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!rsp.valid && (chain_vld == '0)), "chain not empty in reset")
    `MPID_ASSERT(a_stall_holds_chain, clk, rst_n, (rsp.valid && !rsp.ready) |=> $stable(chain_vld), "chain moved while output stalled")
    `MPID_ASSERT(a_decode_reaches_out, clk, rst_n, (adv && tok[ENTRIES].vld && (tok[ENTRIES].op == mpid_pkg::OP_DECODE)) |=> rsp.valid, "decode result lost at chain end")
    `MPID_ASSERT(a_miss_zero_index, clk, rst_n, (rsp.valid && !rsp.hit) |-> (rsp.instr_index == '0), "nonzero index on miss")

endmodule
